FILE: hdl/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg: shared types and constants for the TGA run-length pixel decoder
// Holds the front-to-back command record and the configuration indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package tga_pkg;
   localparam int PALETTE_DEPTH_DEF = 256;

   localparam logic [1:0] CSR_COLOUR_MAPPED = 2'd0;
   localparam logic [1:0] CSR_PIXEL_BYTES   = 2'd1;
   localparam logic [1:0] CSR_ENTRY_BYTES   = 2'd2;
   localparam logic [1:0] CSR_PIXEL_TOTAL   = 2'd3;

   // one finished pixel handed from front to back
   typedef struct packed {
      logic        lookup;     // palette index, resolve in back end
      logic [31:0] word;       // true-colour word or index in low bits
      logic        bad;        // index beyond palette
      logic [7:0]  run;        // run length, before clipping
      logic        alpha_fill; // 3-byte palette entries: force alpha
   } cmd_type;
endpackage
`default_nettype wire

FILE: hdl/tga_ram.sv
// ----------------------------------------------------------------------------
// tga_ram: generic single-write, single-read RAM with registered read
// One write port and one read port; read data is registered and appears in the cycle after the request.
// ----------------------------------------------------------------------------
`default_nettype none
module tga_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [WIDTH/8-1:0]       wr_be,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < WIDTH/8; i++) begin
            if (wr_be[i]) begin
               mem[wr_addr][i*8 +: 8] <= wr_data[i*8 +: 8];
            end
         end
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hdl/tga_front.sv
// ----------------------------------------------------------------------------
// tga_front: byte parser
// Writes palette bytes, tracks packet headers, assembles pixels into commands.
// ----------------------------------------------------------------------------
`default_nettype none
module tga_front import tga_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             colour_mapped,
   input  wire logic [2:0]                       pixel_bytes,
   input  wire logic [2:0]                       palette_entry_bytes,
   input  wire logic                             in_valid,
   output logic                                  in_stall,
   input  wire logic                             in_op,
   input  wire logic [7:0]                       in_byte,
   output logic                                  pal_wr_en,
   output logic      [$clog2(PALETTE_DEPTH)-1:0] pal_wr_addr,
   output logic      [31:0]                      pal_wr_data,
   output logic      [3:0]                       pal_wr_be,
   output logic                                  cmd_valid,
   output cmd_type                               cmd,
   input  wire logic                             cmd_full,
   input  wire logic                             image_end
);
   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [AW+2:0] fill_ff, fill_in;   // palette bytes written so far
   logic [AW:0]   q3_ff, q3_in;       // fill_ff / 3, kept alongside
   logic [1:0]    r3_ff, r3_in;       // fill_ff % 3
   logic [AW:0]   entry;
   logic [1:0]    lane;
   logic         hdr_ff, hdr_in;
   logic         isrun_ff, isrun_in;
   logic [7:0]   left_ff, left_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [31:0]  asm_ff, asm_in;
   logic [31:0]  asm_new;
   logic [2:0]   psize;
   logic         es3, take, done;
   logic [15:0]  idx;

   assign in_stall = cmd_full;
   assign take     = in_valid && !in_stall;
   assign es3      = (palette_entry_bytes == 3'd3);

   always_comb begin
      if (colour_mapped) begin
         psize = (pixel_bytes == 3'd2) ? 3'd2 : 3'd1;
      end else begin
         psize = (pixel_bytes == 3'd4) ? 3'd4 : 3'd3;
      end
   end

   assign asm_new = asm_ff | ({24'd0, in_byte} << {cnt_ff, 3'b000});
   assign done    = take && in_op && !hdr_ff && ({1'b0, cnt_ff} + 3'd1 >= psize);
   assign idx     = (psize == 3'd2) ? asm_new[15:0] : {8'd0, asm_new[7:0]};

   // palette write: entry and byte lane follow the current entry size
   assign entry       = es3 ? q3_ff : fill_ff[AW+2:2];
   assign lane        = es3 ? r3_ff : fill_ff[1:0];
   assign pal_wr_en   = take && !in_op && (entry < (AW+1)'(PALETTE_DEPTH));
   assign pal_wr_addr = entry[AW-1:0];
   assign pal_wr_data = {4{in_byte}};
   assign pal_wr_be   = 4'b0001 << lane;

   always_comb begin
      fill_in = fill_ff;
      q3_in   = q3_ff;
      r3_in   = r3_ff;
      if (pal_wr_en) begin
         fill_in = fill_ff + (AW+3)'(1);
         if (r3_ff == 2'd2) begin
            r3_in = 2'd0;
            q3_in = q3_ff + (AW+1)'(1);
         end else begin
            r3_in = r3_ff + 2'd1;
         end
      end
   end

   always_comb begin
      hdr_in   = hdr_ff;
      isrun_in = isrun_ff;
      left_in  = left_ff;
      cnt_in   = cnt_ff;
      asm_in   = asm_ff;
      if (image_end) begin
         hdr_in = 1'b1; isrun_in = 1'b0; left_in = 8'd0; cnt_in = 2'd0; asm_in = 32'd0;
      end else if (take && in_op) begin
         if (hdr_ff) begin
            hdr_in   = 1'b0;
            isrun_in = in_byte[7];
            left_in  = {1'b0, in_byte[6:0]} + 8'd1;
            cnt_in   = 2'd0;
            asm_in   = 32'd0;
         end else if (!done) begin
            cnt_in = cnt_ff + 2'd1;
            asm_in = asm_new;
         end else begin
            cnt_in = 2'd0;
            asm_in = 32'd0;
            if (isrun_ff) begin
               left_in = 8'd0;
            end else if (left_ff != 8'd0) begin
               left_in = left_ff - 8'd1;
            end
            if (isrun_ff || left_ff <= 8'd1) begin
               hdr_in = 1'b1; isrun_in = 1'b0; left_in = 8'd0;
            end
         end
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.lookup     = colour_mapped && (idx < 16'(PALETTE_DEPTH) || PALETTE_DEPTH > 65535);
      cmd.bad        = colour_mapped && !cmd.lookup;
      cmd.alpha_fill = es3;
      cmd.run        = isrun_ff ? ((left_ff == 8'd0) ? 8'd1 : left_ff) : 8'd1;
      if (!colour_mapped) begin
         cmd.word = (psize == 3'd3) ? (asm_new | 32'hFF00_0000) : asm_new;
      end else if (cmd.lookup) begin
         cmd.word = {16'd0, idx};
      end
   end
   assign cmd_valid = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0; q3_ff <= '0; r3_ff <= '0; hdr_ff <= 1'b1; isrun_ff <= 1'b0;
         left_ff <= '0; cnt_ff <= '0; asm_ff <= '0;
      end else begin
         fill_ff <= fill_in; q3_ff <= q3_in; r3_ff <= r3_in; hdr_ff <= hdr_in;
         isrun_ff <= isrun_in; left_ff <= left_in; cnt_ff <= cnt_in; asm_ff <= asm_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/tga_back.sv
// ----------------------------------------------------------------------------
// tga_back: pixel finisher
// Resolves palette lookups, clips runs at the pixel total, drives the output.
// ----------------------------------------------------------------------------
`default_nettype none
module tga_back import tga_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] pixel_total,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   input  wire logic [31:0] pal_rd_data,
   output logic             cmd_full,
   output logic             out_valid,
   input  wire logic        out_stall,
   output logic [31:0]      out_word,
   output logic [7:0]       out_run,
   output logic             out_last,
   output logic             out_bad,
   output logic             image_end
);
   logic [31:0] emitted_ff, emitted_in;
   logic [31:0] total, remaining;
   logic [7:0]  run;
   logic        last;
   logic        s1_ff, s1_look_ff, s1_fill_ff, s1_bad_ff;
   logic [31:0] s1_word_ff;
   logic [7:0]  s1_run_ff;
   logic        s1_last_ff;
   logic [31:0] word;
   logic [31:0] q_word_ff [2];
   logic [7:0]  q_run_ff  [2];
   logic        q_last_ff [2];
   logic        q_bad_ff  [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        pop;
   logic [2:0]  level;

   assign total     = (pixel_total == 32'd0) ? 32'd1 : pixel_total;
   assign remaining = (emitted_ff < total) ? (total - emitted_ff) : 32'd1;
   assign run       = ({24'd0, cmd.run} > remaining) ? remaining[7:0] : cmd.run;
   assign last      = ({24'd0, cmd.run} >= remaining);
   assign image_end = cmd_valid && last;

   always_comb begin
      emitted_in = emitted_ff;
      if (cmd_valid) begin
         emitted_in = last ? 32'd0 : emitted_ff + {24'd0, run};
      end
   end

   always_comb begin
      if (!s1_look_ff) begin
         word = s1_word_ff;
      end else if (s1_fill_ff) begin
         word = {8'hFF, pal_rd_data[23:0]};
      end else begin
         word = pal_rd_data;
      end
   end

   // two-entry result queue; level is its occupancy after this edge.
   // A new pixel may enter s1 only if the queue keeps a free slot for it.
   assign pop      = (count_ff != 2'd0) && !out_stall;
   assign level    = {1'b0, count_ff} + {2'd0, s1_ff} - {2'd0, pop};
   assign cmd_full = (level >= 3'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         emitted_ff <= '0; s1_ff <= 1'b0; count_ff <= '0;
         wr_ptr_ff  <= 1'b0; rd_ptr_ff <= 1'b0;
      end else begin
         emitted_ff <= emitted_in;
         s1_ff      <= cmd_valid;
         count_ff   <= level[1:0];
         if (s1_ff) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (cmd_valid) begin
         s1_look_ff <= cmd.lookup; s1_fill_ff <= cmd.alpha_fill; s1_bad_ff <= cmd.bad;
         s1_word_ff <= cmd.word; s1_run_ff <= run; s1_last_ff <= last;
      end
      if (s1_ff) begin
         q_word_ff[wr_ptr_ff] <= word;       q_run_ff[wr_ptr_ff] <= s1_run_ff;
         q_last_ff[wr_ptr_ff] <= s1_last_ff; q_bad_ff[wr_ptr_ff] <= s1_bad_ff;
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_word  = q_word_ff[rd_ptr_ff];
   assign out_run   = q_run_ff[rd_ptr_ff];
   assign out_last  = q_last_ff[rd_ptr_ff];
   assign out_bad   = q_bad_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_run != 8'd0) else $error("zero run length");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      image_end |=> emitted_ff == 32'd0) else $error("count not cleared");
   a_bad_word: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_bad) |-> out_word == 32'd0) else $error("bad index word not zero");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s1_ff |-> count_ff != 2'd2) else $error("result queue overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_stall) |=> out_valid && $stable(out_word) && $stable(out_run))
      else $error("stalled beat changed");
`endif
endmodule
`default_nettype wire

FILE: hdl/tga_rle_pixel_decoder.sv
// The accepted byte that completes a pixel reaches rsp_valid through s1 (palette read) and the result queue.
// One byte per cycle while req_stall is low; a pixel takes 1-2 bytes colour-mapped, else 3-4; a header one.
// Back end holds a palette-read stage and a two-entry result queue; req_stall
// rises only when a new pixel could overflow that queue under rsp_stall.
// Reset clears packet state, palette fill position and pixel count, and returns config to its defaults.
// Palette contents are not cleared.
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder: TGA run-length pixel decoder top level
// Front parser, palette RAM and back finisher with clipping.
// ----------------------------------------------------------------------------
`default_nettype none
module tga_rle_pixel_decoder import tga_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_pixel_word,
   output logic [7:0]       rsp_run_length,
   output logic             rsp_last_of_image,
   output logic             rsp_bad_index,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int AW = $clog2(PALETTE_DEPTH);

   logic        cmap_ff;
   logic [2:0]  pbytes_ff, ebytes_ff;
   logic [31:0] total_ff;
   logic        pal_wr_en;
   logic [AW-1:0] pal_wr_addr;
   logic [31:0] pal_wr_data, pal_rd_data;
   logic [3:0]  pal_wr_be;
   logic        cmd_valid, image_end;
   cmd_type     cmd;
   logic        full;

   // back end: cmd -> s1 (palette read) -> result queue. The back end raises
   // full when a new pixel could not be guaranteed a queue slot.

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cmap_ff <= 1'b0; pbytes_ff <= 3'd4; ebytes_ff <= 3'd4; total_ff <= 32'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COLOUR_MAPPED: cmap_ff   <= csr_data[0];
            CSR_PIXEL_BYTES:   pbytes_ff <= csr_data[2:0];
            CSR_ENTRY_BYTES:   ebytes_ff <= csr_data[2:0];
            CSR_PIXEL_TOTAL:   total_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   tga_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
      .clock, .reset,
      .colour_mapped(cmap_ff), .pixel_bytes(pbytes_ff), .palette_entry_bytes(ebytes_ff),
      .in_valid(req_valid), .in_stall(req_stall), .in_op(req_op), .in_byte(req_data_byte),
      .pal_wr_en, .pal_wr_addr, .pal_wr_data, .pal_wr_be,
      .cmd_valid, .cmd, .cmd_full(full), .image_end
   );

   tga_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_palette (
      .clock, .wr_en(pal_wr_en), .wr_addr(pal_wr_addr), .wr_data(pal_wr_data),
      .wr_be(pal_wr_be), .rd_en(cmd_valid), .rd_addr(cmd.word[AW-1:0]),
      .rd_data(pal_rd_data)
   );

   tga_back u_back (
      .clock, .reset, .pixel_total(total_ff),
      .cmd_valid, .cmd, .pal_rd_data, .cmd_full(full),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_word(rsp_pixel_word), .out_run(rsp_run_length),
      .out_last(rsp_last_of_image), .out_bad(rsp_bad_index), .image_end
   );
endmodule
`default_nettype wire
